[rtl/pra_pkg.sv]
package pra_pkg;

    // sizes
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int COUNT_BITS = 8;

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int OFFS_W  = $clog2(PAGE_BYTES);
    localparam int DEPTH_W = PAGE_W + 1;

    // fixed field widths
    localparam int ADDR_W = 27;
    localparam int CFG_W  = 15;
    localparam int REF_W  = 8;
    localparam int STAT_W = 3;
    localparam int CMD_W  = 2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADDREF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COW    = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OOM  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SAT  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address_offset;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_address;
        logic [REF_W-1:0]  reference_count;
        logic              page_released;
    } t_out_item;

    // count memory port
    typedef struct packed {
        logic                  we;
        logic [PAGE_W-1:0]     waddr;
        logic [COUNT_BITS-1:0] wdata;
        logic [PAGE_W-1:0]     raddr;
    } t_cnt_port;

    // free stack memory port
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [PAGE_W-1:0] wdata;
        logic [PAGE_W-1:0] raddr;
    } t_stk_port;

    typedef struct packed {
        logic               clearing;
        logic [DEPTH_W-1:0] depth;
    } t_seq_stat;

endpackage

[rtl/pra_ram.sv]
module pra_ram #(
    parameter int W = 8,
    parameter int N = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(N)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(N)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [N];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pra_seq.sv]
module pra_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  pra_pkg::t_in_item                 i_in_item,
    output logic                              o_in_stall,
    input  logic                              i_cfg_we,
    input  logic [pra_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_slot_free,
    output logic                              o_res_valid,
    output pra_pkg::t_out_item                o_res,
    output pra_pkg::t_cnt_port                o_cnt_port,
    input  logic [pra_pkg::COUNT_BITS-1:0]    i_cnt_rdata,
    output pra_pkg::t_stk_port                o_stk_port,
    input  logic [pra_pkg::PAGE_W-1:0]        i_stk_rdata,
    output pra_pkg::t_seq_stat                o_stat
);
    import pra_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_WR2   = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [PAGE_W-1:0]  r_clr, n_clr;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [CFG_W-1:0]   r_first, n_first;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [PAGE_W-1:0]  r_np, n_np;
    t_out_item          r_res, n_res;

    t_out_item          x_res;
    logic               x_wr2;
    logic [PAGE_W-1:0]  pg;
    logic [ADDR_W-1:0]  pg_full;
    logic               pg_oob, aligned, empty, full;
    logic [COUNT_BITS-1:0] c_dec;
    logic [DEPTH_W-1:0] depth_m1;
    logic [ADDR_W-1:0]  top_addr;
    logic [PAGE_W-1:0]  in_pg;

    assign pg       = r_addr[OFFS_W +: PAGE_W];
    assign pg_full  = ADDR_W'(r_addr >> OFFS_W);
    assign pg_oob   = pg_full >= ADDR_W'(NUM_PAGES);
    assign aligned  = r_addr[OFFS_W-1:0] == '0;
    assign empty    = r_depth == '0;
    assign full     = r_depth == DEPTH_W'(NUM_PAGES);
    assign c_dec    = (i_cnt_rdata != '0) ? i_cnt_rdata - CNT_ONE : '0;
    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign top_addr = ADDR_W'(i_stk_rdata) << OFFS_W;
    assign in_pg    = i_in_item.address_offset[OFFS_W +: PAGE_W];

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_depth = r_depth;
        n_first = i_cfg_we ? i_cfg_wdata : r_first;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_np    = r_np;
        n_res   = r_res;

        x_res   = '{status: STAT_OK, result_address: '0, reference_count: '0,
                    page_released: 1'b0};
        x_wr2   = 1'b0;

        o_cnt_port = '{we: 1'b0, waddr: pg, wdata: '0, raddr: in_pg};
        o_stk_port = '{we: 1'b0, waddr: r_depth[PAGE_W-1:0], wdata: pg,
                       raddr: depth_m1[PAGE_W-1:0]};
        o_res_valid = 1'b0;
        o_res       = r_res;

        case (r_state)
            S_CLEAR: begin
                o_cnt_port.we    = 1'b1;
                o_cnt_port.waddr = r_clr;
                n_clr = r_clr + PAGE_W'(1);
                if (r_clr == PAGE_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_item.command;
                    n_addr  = i_in_item.address_offset;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (empty) begin
                            x_res.status = STAT_OOM;
                        end else begin
                            n_depth = depth_m1;
                            o_cnt_port.we    = 1'b1;
                            o_cnt_port.waddr = i_stk_rdata;
                            o_cnt_port.wdata = CNT_ONE;
                            x_res.result_address  = top_addr;
                            x_res.reference_count = REF_W'(CNT_ONE);
                        end
                    end
                    CMD_FREE: begin
                        if (!aligned || pg_full < ADDR_W'(r_first) || pg_oob) begin
                            x_res.status = STAT_BAD;
                        end else begin
                            o_cnt_port.we    = 1'b1;
                            o_cnt_port.wdata = c_dec;
                            if (c_dec != '0) begin
                                x_res.reference_count = REF_W'(c_dec);
                            end else if (full) begin
                                x_res.status = STAT_FULL;
                            end else begin
                                o_stk_port.we = 1'b1;
                                n_depth = r_depth + DEPTH_W'(1);
                                x_res.page_released = 1'b1;
                            end
                        end
                    end
                    CMD_ADDREF: begin
                        if (pg_oob) begin
                            x_res.status = STAT_BAD;
                        end else if (i_cnt_rdata == CNT_MAX) begin
                            x_res.status = STAT_SAT;
                            x_res.reference_count = REF_W'(CNT_MAX);
                        end else begin
                            o_cnt_port.we    = 1'b1;
                            o_cnt_port.wdata = i_cnt_rdata + CNT_ONE;
                            x_res.reference_count = REF_W'(i_cnt_rdata + CNT_ONE);
                        end
                    end
                    default: begin
                        // copy on write
                        if (pg_oob) begin
                            x_res.status = STAT_BAD;
                        end else if (i_cnt_rdata <= CNT_ONE) begin
                            x_res.result_address  = r_addr;
                            x_res.reference_count = REF_W'(i_cnt_rdata);
                        end else if (empty) begin
                            x_res.status = STAT_OOM;
                            x_res.reference_count = REF_W'(i_cnt_rdata);
                        end else begin
                            n_depth = depth_m1;
                            o_cnt_port.we = 1'b1;
                            x_res.result_address = top_addr;
                            if (i_stk_rdata == pg) begin
                                // new page is the old one: set to one, then dropped to zero
                                o_cnt_port.wdata = '0;
                            end else begin
                                o_cnt_port.wdata = c_dec;
                                x_res.reference_count = REF_W'(c_dec);
                                x_wr2 = 1'b1;
                                n_np  = i_stk_rdata;
                            end
                        end
                    end
                endcase
                n_res = x_res;
                o_res = x_res;
                if (x_wr2) begin
                    n_state = S_WR2;
                end else if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_WR2: begin
                o_cnt_port.we    = 1'b1;
                o_cnt_port.waddr = r_np;
                o_cnt_port.wdata = CNT_ONE;
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_depth <= '0;
            r_first <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_depth <= n_depth;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_np   <= n_np;
        r_res  <= n_res;
    end

    assign o_in_stall = r_state != S_IDLE;
    assign o_stat     = '{clearing: r_state == S_CLEAR, depth: r_depth};

endmodule

[rtl/refcounted_page_allocator.sv]
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  i_in_item  (command, address_offset)
// out       output     o_out_valid / i_out_stall o_out_item (status, address, count, released)
// cfg       input      i_cfg_we                 i_cfg_wdata (first usable page)
//
// an item passes S_IDLE (count and stack memory read), then S_EXEC (modify and write back);
// a shared copy on write that pops another page adds S_WR2, the second count memory write
// after reset the count memory is cleared one entry a cycle with o_in_stall high;
// configuration writes are taken during the clear
// the output register lets the next item in while a result waits; a stalled
// output only holds the sequencer once a second result is ready
module refcounted_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pra_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pra_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [pra_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import pra_pkg::*;

    // memory ports and sequencer status
    t_cnt_port             cnt_port;
    t_stk_port             stk_port;
    t_seq_stat             stat;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [PAGE_W-1:0]     stk_rdata;

    // result hand-off into the output register
    logic                  res_valid;
    t_out_item             res;
    logic                  slot_free;

    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item;

    // reference count per page
    pra_ram #(.W(COUNT_BITS), .N(NUM_PAGES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_port.we),
        .i_waddr (cnt_port.waddr),
        .i_wdata (cnt_port.wdata),
        .i_raddr (cnt_port.raddr),
        .o_rdata (cnt_rdata)
    );

    // lifo of free page numbers, top at depth - 1
    pra_ram #(.W(PAGE_W), .N(NUM_PAGES)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_port.we),
        .i_waddr (stk_port.waddr),
        .i_wdata (stk_port.wdata),
        .i_raddr (stk_port.raddr),
        .o_rdata (stk_rdata)
    );

    pra_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_cnt_port  (cnt_port),
        .i_cnt_rdata (cnt_rdata),
        .o_stk_port  (stk_port),
        .i_stk_rdata (stk_rdata),
        .o_stat      (stat)
    );

    // output register is free when empty or being taken this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // no item is taken while the count memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> o_in_stall)
        else $error("item accepted during count clear");

    // the stack never holds more pages than exist
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.depth <= DEPTH_W'(NUM_PAGES))
        else $error("free stack depth out of range");

    // a push grows the stack by exactly one
    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_port.we |=> stat.depth == $past(stat.depth) + DEPTH_W'(1))
        else $error("push did not advance stack depth");

    // a result never overwrites a stalled one
    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled item");
`endif

endmodule

[tb/refcounted_page_allocator_checker.sv]
`timescale 1ns / 1ps

module refcounted_page_allocator_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  pra_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  pra_pkg::t_out_item        i_out_item,
    input  logic                      i_cfg_we,
    input  logic [pra_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_pending,
    output int                        o_fail_count,
    output int                        o_checked,
    output int                        o_flagged
);
    import pra_pkg::*;

    // shadow copy of the allocator state
    logic [COUNT_BITS-1:0] page_count [NUM_PAGES];
    logic [PAGE_W-1:0]     free_pages [NUM_PAGES];
    int                    free_depth;
    logic [CFG_W-1:0]      first_page;

    t_out_item due_results [$];
    int        fails;
    int        checked;
    int        flagged;

    function automatic logic [ADDR_W-1:0] page_base(input logic [PAGE_W-1:0] pg);
        return ADDR_W'({pg, {OFFS_W{1'b0}}});
    endfunction

    // outcome of one command, updating the shadow state
    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item         r;
        int                pg;
        logic [PAGE_W-1:0] p;
        logic [PAGE_W-1:0] np;
        r  = '0;
        pg = int'(it.address_offset / PAGE_BYTES);
        p  = pg[PAGE_W-1:0];
        case (it.command)
            CMD_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = STAT_OOM;
                end else begin
                    free_depth--;
                    np = free_pages[free_depth];
                    page_count[np] = CNT_ONE;
                    r.result_address  = page_base(np);
                    r.reference_count = REF_W'(CNT_ONE);
                end
            end
            CMD_FREE: begin
                if (it.address_offset[OFFS_W-1:0] != '0 || pg < int'(first_page) ||
                    pg >= NUM_PAGES) begin
                    r.status = STAT_BAD;
                end else begin
                    if (page_count[p] != '0)
                        page_count[p] = page_count[p] - 1'b1;
                    if (page_count[p] != '0) begin
                        r.reference_count = REF_W'(page_count[p]);
                    end else if (free_depth >= NUM_PAGES) begin
                        r.status = STAT_FULL;
                    end else begin
                        free_pages[free_depth] = p;
                        free_depth++;
                        r.page_released = 1'b1;
                    end
                end
            end
            default: begin
                if (pg >= NUM_PAGES) begin
                    r.status = STAT_BAD;
                end else if (it.command == CMD_ADDREF) begin
                    if (page_count[p] == CNT_MAX) begin
                        r.status = STAT_SAT;
                    end else begin
                        page_count[p] = page_count[p] + 1'b1;
                    end
                    r.reference_count = REF_W'(page_count[p]);
                end else if (page_count[p] <= CNT_ONE) begin
                    r.result_address  = it.address_offset;
                    r.reference_count = REF_W'(page_count[p]);
                end else if (free_depth == 0) begin
                    r.status          = STAT_OOM;
                    r.reference_count = REF_W'(page_count[p]);
                end else begin
                    // the new page may be the old one when it was pushed twice
                    free_depth--;
                    np = free_pages[free_depth];
                    page_count[np] = CNT_ONE;
                    if (page_count[p] != '0)
                        page_count[p] = page_count[p] - 1'b1;
                    r.result_address  = page_base(np);
                    r.reference_count = REF_W'(page_count[p]);
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item due;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PAGES; i++)
                page_count[i] = '0;
            free_depth = 0;
            first_page = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we)
                first_page = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d address %0h count %0d released %0b",
                             $time, i_out_item.status, i_out_item.result_address,
                             i_out_item.reference_count, i_out_item.page_released);
                    fails++;
                end else begin
                    due = due_results.pop_front();
                    check_field("status", due.status, i_out_item.status);
                    check_field("result_address", due.result_address,
                                i_out_item.result_address);
                    check_field("reference_count", due.reference_count,
                                i_out_item.reference_count);
                    check_field("page_released", due.page_released, i_out_item.page_released);
                    checked++;
                    if (due.status != STAT_OK)
                        flagged++;
                end
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(apply_command(i_in_item));
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_flagged    <= flagged;
    end

endmodule

[tb/tb_refcounted_page_allocator.sv]
`timescale 1ns / 1ps

module tb_refcounted_page_allocator;
    import pra_pkg::*;

    localparam int TOP_PAGE = NUM_PAGES - 1;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_item   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_item;

    int pending;
    int fail_count;
    int checked;
    int flagged;

    // idle percentages, hold-off request and bookkeeping for the summary
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_len     = 0;
    int cfg_settings = 0;

    refcounted_page_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    refcounted_page_allocator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // safety net: a correct run needs well under a fifth of this
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall, plus one long hold-off counted here
    int  hold_cnt   = 0;
    bit  hold_taken = 1'b0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            hold_cnt   <= 0;
            hold_taken <= 1'b0;
        end else if (hold_len != 0 && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt   <= hold_len - 1;
            out_stall  <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] page_addr(input int pg);
        return ADDR_W'(pg) << OFFS_W;
    endfunction

    // offer one command, with random gaps first, and wait until it is taken
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, address_offset: addr};
        do @(posedge clk); while (in_stall);
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_first_page(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    // random commands on a window of 16 pages around the lowest freeable page,
    // so frees feed the stack and allocates, add references and copies on
    // write work on the same pages; a few addresses are pure noise
    task automatic random_phase(input int n, input int tx, input int rx,
                                input logic [CFG_W-1:0] first, input int hold);
        int                base;
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        wait_drained();
        set_first_page(first);
        tx_idle_pct = tx;
        rx_idle_pct <= rx;
        hold_len    <= hold;
        base = (first < 4) ? 0 : int'(first) - 4;
        if (base > NUM_PAGES - 16)
            base = NUM_PAGES - 16;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 25)
                cmd = CMD_ALLOC;
            else if (r < 55)
                cmd = CMD_FREE;
            else if (r < 80)
                cmd = CMD_ADDREF;
            else
                cmd = CMD_COW;
            if ($urandom_range(99) < 8) begin
                addr = ADDR_W'($urandom);
            end else begin
                addr = page_addr(base + $urandom_range(15));
                // occasional misaligned offset inside the page
                if ($urandom_range(9) == 0)
                    addr[OFFS_W-1:0] = OFFS_W'($urandom_range(PAGE_BYTES - 1, 1));
            end
            offer(cmd, addr);
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // the block is still clearing its counts, the register write is taken anyway
        set_first_page('0);

        // directed part, lowest setting, no idling
        offer(CMD_ALLOC, '0);                       // empty stack: out of memory
        offer(CMD_COW, page_addr(5));               // unshared page comes back as is
        offer(CMD_FREE, page_addr(3) + ADDR_W'(1)); // misaligned free
        offer(CMD_FREE, page_addr(3));              // count zero, pushed
        offer(CMD_FREE, page_addr(3));              // count zero, pushed again
        offer(CMD_ALLOC, '0);
        offer(CMD_ADDREF, page_addr(3));
        offer(CMD_COW, page_addr(3));               // shared, pops its own duplicate
        offer(CMD_ADDREF, page_addr(7));
        offer(CMD_ADDREF, page_addr(7));
        offer(CMD_COW, page_addr(7));               // shared with nothing left to pop
        offer(CMD_FREE, page_addr(7));              // decrement, still referenced
        offer(CMD_COW, page_addr(7) + 12'h123);     // unaligned, count one
        offer(CMD_FREE, page_addr(TOP_PAGE));       // highest page
        offer(CMD_ADDREF, '1);                      // highest offset, unaligned
        offer(CMD_COW, '1);
        offer(CMD_FREE, page_addr(0));              // page zero at lowest setting
        offer(CMD_ALLOC, '0);
        offer(CMD_ALLOC, '0);
        offer(CMD_ALLOC, '0);

        // random part: receiver-heavy idling, then sender-heavy, then none with
        // a long hold-off on the result side so the input backs up
        random_phase(60, 38, 51, '1, 0);
        random_phase(60, 51, 38, CFG_W'($urandom_range(NUM_PAGES - 2, 1)), 0);
        random_phase(60, 0, 0, CFG_W'(5), 400);

        // saturate the top page, then free, share and copy it
        wait_drained();
        repeat (int'(CNT_MAX) + 2)
            offer(CMD_ADDREF, page_addr(TOP_PAGE));
        offer(CMD_FREE, page_addr(TOP_PAGE));
        offer(CMD_ADDREF, page_addr(TOP_PAGE));
        offer(CMD_COW, page_addr(TOP_PAGE));
        repeat (2)
            offer(CMD_ALLOC, '0);

        wait_drained();
        repeat (16) @(posedge clk);

        $display("covered all four commands in directed, random and saturation traffic");
        $display("%0d results compared, %0d with a non-ok status, %0d register settings",
                 checked, flagged, cfg_settings);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
